// ===== rtl/fovlda_pkg.sv =====
// ----------------------------------------------------------------------------
// FOV lens distortion: shared definitions
// Widths, constants, register indexes and small tables for the point pipeline.
// ----------------------------------------------------------------------------
package fovlda_pkg;

	// Point fields and configuration
	localparam int XW        = 18;
	localparam int COEF_W    = 24;
	localparam int T_W       = 16;
	localparam int TERMS_W   = 3;
	localparam int NCOEF     = 6;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam logic [T_W-1:0]              TAN_RESET   = 16'd18919;
	localparam logic [TERMS_W-1:0]          TERMS_RESET = 3'd1;
	localparam logic signed [COEF_W-1:0]    COEF0_RESET = 24'sd65536;

	// Square root chain: radicand 4*(x^2+y^2), one root bit per cell
	localparam int RAD_W     = 38;
	localparam int ROOT_W    = 19;
	localparam int SQ_REM_W  = 21;
	localparam int SQRT_N    = ROOT_W;

	// Tangent argument and rotation chain
	localparam int UF_W      = ROOT_W + T_W - 1;
	localparam int U_W       = 31;
	localparam int SMALL_W   = 24;
	localparam int C_W       = 33;
	localparam int CORDIC_N  = 30;

	// Polynomial, ratio and scale factor
	localparam int P_W       = 42;
	localparam int R_W       = 42;
	localparam int F_W       = 43;
	localparam int CLAMP_W   = 48;
	localparam int SR_W      = 17;

	// Divider: dividend sin << 16, one quotient bit per cell
	localparam int D_W       = 32;
	localparam int SN_W      = 32;
	localparam int NQ_W      = 48;
	localparam int DIV_N     = NQ_W;

	localparam logic [UF_W-1:0]         HALF_PI_Q30  = 34'd1686629713;
	localparam logic signed [C_W-1:0]   CORDIC_K_Q30 = 33'sd652032874;
	localparam logic signed [P_W-1:0]   ACC_LIM      = 42'sh10000000000;
	localparam logic [NQ_W-1:0]         Q_LIM        = 48'h010000000000;
	localparam logic [SR_W-1:0]         ONE_Q16      = 17'd65536;
	localparam logic signed [XW-1:0]    OUT_MAX      = 18'sd131071;
	localparam logic signed [XW-1:0]    OUT_MIN      = -18'sd131072;

	localparam logic [U_W-1:0] ATAN_Q30 [CORDIC_N] = '{
		31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
		31'd33543516,  31'd16775851,  31'd8388437,   31'd4194283,   31'd2097149,
		31'd1048576,   31'd524288,    31'd262144,    31'd131072,    31'd65536,
		31'd32768,     31'd16384,     31'd8192,      31'd4096,      31'd2048,
		31'd1024,      31'd512,       31'd256,       31'd128,       31'd64,
		31'd32,        31'd16,        31'd8,         31'd4,         31'd2
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TAN_HALF_FOV = 3'd0,
		REG_TERMS_IN_USE = 3'd1,
		REG_COEF_C0      = 3'd2,
		REG_COEF_C1      = 3'd3,
		REG_COEF_C2      = 3'd4,
		REG_COEF_C3      = 3'd5,
		REG_COEF_C4      = 3'd6,
		REG_COEF_C5      = 3'd7
	} reg_idx_t;

	// Marks the Horner step that only multiplies by r (the missing r^2 term).
	localparam int HORNER_NONE = -1;

	// Coefficient taken by Horner step k when max_terms coefficients exist.
	function automatic int horner_coef_idx(input int k, input int max_terms);
		int idx;
		if (max_terms == 1)
			idx = 0;
		else if (k < max_terms - 2)
			idx = max_terms - 1 - k;
		else if (k == max_terms - 2)
			idx = HORNER_NONE;
		else
			idx = max_terms - k;
		return idx;
	endfunction

	// Saturate a wide signed value to the accumulator range of +-2^40.
	function automatic logic signed [P_W-1:0] clamp_acc(input logic signed [CLAMP_W-1:0] v);
		logic signed [P_W-1:0] res;
		if (v > CLAMP_W'(ACC_LIM))
			res = ACC_LIM;
		else if (v < -CLAMP_W'(ACC_LIM))
			res = -ACC_LIM;
		else
			res = v[P_W-1:0];
		return res;
	endfunction

	// Floor division by three of a four-bit value.
	function automatic logic [2:0] div3_small(input logic [3:0] v);
		logic [2:0] q;
		case (v)
			4'd0, 4'd1, 4'd2:    q = 3'd0;
			4'd3, 4'd4, 4'd5:    q = 3'd1;
			4'd6, 4'd7, 4'd8:    q = 3'd2;
			4'd9, 4'd10, 4'd11:  q = 3'd3;
			4'd12, 4'd13, 4'd14: q = 3'd4;
			default:             q = 3'd5;
		endcase
		return q;
	endfunction

endpackage

// ===== rtl/fov_lens_distortion_apply_unit.sv =====
// ----------------------------------------------------------------------------
// FOV lens distortion apply unit
// Scales a centred Q2.15 point by P(r) + tan(r*t)/(r*t) in a fully
// pipelined chain of cells, one point per clock while not stalled.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   in        sink       in_valid / in_ready     x_in, y_in
//   out       source     out_valid / out_ready   x_out, y_out, range_flag
//   cfg       sink       cfg_we (no back-pressure) cfg_idx, cfg_wdata
//
// A new transaction can be taken on every clock unless the output is held.
// Each passes the squared-radius stage, the 19-cell square root chain, the
// tangent argument stage, the 30-cell rotation chain, the divisor stage, the
// 48-cell divider and the ratio, scale factor and output stages. Reset clears
// the stage valid bits and loads the register defaults. When a result waits
// at the output the whole pipeline holds and in_ready falls in the same cycle.
//
module fov_lens_distortion_apply_unit import fovlda_pkg::*; #(
	parameter int MAX_TERMS = NCOEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [XW-1:0]   x_in,
	input  logic signed [XW-1:0]   y_in,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [XW-1:0]   x_out,
	output logic signed [XW-1:0]   y_out,
	output logic                   range_flag,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	// Stage numbers, counted in registers from the accepting edge.
	localparam int ST_A  = 1;
	localparam int ST_R  = ST_A + SQRT_N;
	localparam int ST_U  = ST_R + 1;
	localparam int ST_S  = ST_U + 1;
	localparam int ST_CX = ST_U + CORDIC_N;
	localparam int ST_D  = ST_CX + 1;
	localparam int ST_Q  = ST_D + DIV_N;
	localparam int ST_RT = ST_Q + 1;
	localparam int ST_F  = ST_RT + 1;
	localparam int ST_O  = ST_F + 1;

	// The polynomial has one extra multiply-only step when it has an r term.
	localparam int HN   = (MAX_TERMS > 1) ? MAX_TERMS + 1 : 1;
	localparam int ST_P = ST_R + HN;

	localparam int XY_DLY  = ST_F - ST_A;
	localparam int OVF_DLY = ST_F - ST_U;
	localparam int U_DLY   = ST_CX - ST_U;
	localparam int SM_DLY  = ST_Q - ST_S;
	localparam int BAD_DLY = ST_Q - ST_D;
	localparam int P_DLY   = ST_RT - ST_P;

	localparam int OP_W = XW + F_W;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [T_W-1:0]           tan_q;
	logic [TERMS_W-1:0]       terms_q;
	logic signed [COEF_W-1:0] coef_q [NCOEF];
	logic [TERMS_W-1:0]       n_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tan_q   <= TAN_RESET;
			terms_q <= TERMS_RESET;
			coef_q[0] <= COEF0_RESET;
			for (int i = 1; i < NCOEF; i++)
				coef_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_TAN_HALF_FOV: tan_q     <= cfg_wdata[T_W-1:0];
				REG_TERMS_IN_USE: terms_q   <= cfg_wdata[TERMS_W-1:0];
				REG_COEF_C0:      coef_q[0] <= $signed(cfg_wdata);
				REG_COEF_C1:      coef_q[1] <= $signed(cfg_wdata);
				REG_COEF_C2:      coef_q[2] <= $signed(cfg_wdata);
				REG_COEF_C3:      coef_q[3] <= $signed(cfg_wdata);
				REG_COEF_C4:      coef_q[4] <= $signed(cfg_wdata);
				REG_COEF_C5:      coef_q[5] <= $signed(cfg_wdata);
				default: ;
			endcase
		end
	end

	// A count above the number of fitted terms uses all of them.
	assign n_eff = (terms_q > TERMS_W'(MAX_TERMS)) ? TERMS_W'(MAX_TERMS) : terms_q;

	// ------------------------------------------------------------------
	// Flow control: the whole pipeline advances together. It moves whenever
	// the output register is empty or is being emptied in this cycle.
	// ------------------------------------------------------------------
	logic          adv;
	logic [ST_O:1] vld_q;

	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[ST_O];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[ST_O-1:1], in_valid};
		end
	end

	// ------------------------------------------------------------------
	// Stage A: squared radius, scaled by four so the root comes out Q3.16.
	// ------------------------------------------------------------------
	logic signed [2*XW-1:0] xx;
	logic signed [2*XW-1:0] yy;
	logic [RAD_W-3:0]       ss;
	logic signed [XW-1:0]   x_s1;
	logic signed [XW-1:0]   y_s1;
	logic [RAD_W-1:0]       rad_s1;

	always_comb begin
		xx = x_in * x_in;
		yy = y_in * y_in;
		ss = {1'b0, xx[2*XW-2:0]} + {1'b0, yy[2*XW-2:0]};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1   <= x_in;
			y_s1   <= y_in;
			rad_s1 <= {ss, 2'b00};
		end
	end

	// ------------------------------------------------------------------
	// Square root chain: one root bit per cell.
	// ------------------------------------------------------------------
	logic [RAD_W-1:0]    sq_rad  [SQRT_N+1];
	logic [SQ_REM_W-1:0] sq_rem  [SQRT_N+1];
	logic [ROOT_W-1:0]   sq_root [SQRT_N+1];

	assign sq_rad[0]  = rad_s1;
	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
		fovlda_sqrt_cell u_cell (
			.clk      (clk),
			.en       (adv),
			.rad_in   (sq_rad[k]),
			.rem_in   (sq_rem[k]),
			.root_in  (sq_root[k]),
			.rad_out  (sq_rad[k+1]),
			.rem_out  (sq_rem[k+1]),
			.root_out (sq_root[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Stage U: tangent argument u = (r * t) >> 1 in Q.30, and the flag for
	// an argument at or past pi/2.
	// ------------------------------------------------------------------
	logic [ROOT_W+T_W-1:0] rt;
	logic [UF_W-1:0]       uf;
	logic [U_W-1:0]        u_s21;
	logic                  ovf_s21;

	always_comb begin
		rt = sq_root[SQRT_N] * tan_q;
		uf = rt[ROOT_W+T_W-1:1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s21   <= uf[U_W-1:0];
			ovf_s21 <= (uf >= HALF_PI_Q30);
		end
	end

	// Small arguments use the series 1 + u^2/3 instead of the rotation.
	logic [2*SMALL_W-1:0] uu;
	logic                 small_s22;
	logic [SR_W-1:0]      sr_s22;

	assign uu = u_s21[SMALL_W-1:0] * u_s21[SMALL_W-1:0];

	always_ff @(posedge clk) begin
		if (adv) begin
			small_s22 <= (u_s21[U_W-1:SMALL_W] == '0);
			sr_s22    <= ONE_Q16 + SR_W'(div3_small(uu[2*SMALL_W-1 -: 4]));
		end
	end

	// ------------------------------------------------------------------
	// Polynomial chain, running alongside the rotation chain. Each cell is
	// one Horner step; the step that stands for the missing r^2 term only
	// multiplies by r.
	// ------------------------------------------------------------------
	logic signed [P_W-1:0] hp [HN+1];
	logic [ROOT_W-1:0]     hr [HN+1];

	assign hp[0] = '0;
	assign hr[0] = sq_root[SQRT_N];

	for (genvar k = 0; k < HN; k++) begin : g_horner
		localparam int CI = horner_coef_idx(k, MAX_TERMS);
		logic signed [COEF_W-1:0] hc;
		logic                     he;
		if (CI == HORNER_NONE) begin : g_extra
			assign hc = '0;
			assign he = 1'b1;
		end else begin : g_term
			assign hc = coef_q[CI];
			assign he = (TERMS_W'(CI) < n_eff);
		end
		fovlda_horner_cell u_cell (
			.clk     (clk),
			.en      (adv),
			.p_in    (hp[k]),
			.r_in    (hr[k]),
			.coef    (hc),
			.coef_en (he),
			.p_out   (hp[k+1]),
			.r_out   (hr[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Rotation chain: cos and sin of u from a fixed start vector.
	// ------------------------------------------------------------------
	logic signed [C_W-1:0] cx [CORDIC_N+1];
	logic signed [C_W-1:0] cy [CORDIC_N+1];
	logic signed [C_W-1:0] cz [CORDIC_N+1];

	assign cx[0] = CORDIC_K_Q30;
	assign cy[0] = '0;
	assign cz[0] = $signed({2'b00, u_s21});

	for (genvar k = 0; k < CORDIC_N; k++) begin : g_cordic
		fovlda_cordic_cell #(
			.IDX (k)
		) u_cell (
			.clk    (clk),
			.en     (adv),
			.cx_in  (cx[k]),
			.cy_in  (cy[k]),
			.z_in   (cz[k]),
			.cx_out (cx[k+1]),
			.cy_out (cy[k+1]),
			.z_out  (cz[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Side lines carrying values past the long chains.
	// ------------------------------------------------------------------
	logic signed [XW-1:0]  x_dl_q   [XY_DLY];
	logic signed [XW-1:0]  y_dl_q   [XY_DLY];
	logic                  ovf_dl_q [OVF_DLY];
	logic [U_W-1:0]        u_dl_q   [U_DLY];
	logic                  sm_dl_q  [SM_DLY];
	logic [SR_W-1:0]       sr_dl_q  [SM_DLY];
	logic                  bad_dl_q [BAD_DLY];
	logic signed [P_W-1:0] p_dl_q   [P_DLY];
	logic                  bad_s52;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_dl_q[0]   <= x_s1;
			y_dl_q[0]   <= y_s1;
			ovf_dl_q[0] <= ovf_s21;
			u_dl_q[0]   <= u_s21;
			sm_dl_q[0]  <= small_s22;
			sr_dl_q[0]  <= sr_s22;
			bad_dl_q[0] <= bad_s52;
			p_dl_q[0]   <= hp[HN];
			for (int i = 1; i < XY_DLY; i++) begin
				x_dl_q[i] <= x_dl_q[i-1];
				y_dl_q[i] <= y_dl_q[i-1];
			end
			for (int i = 1; i < OVF_DLY; i++)
				ovf_dl_q[i] <= ovf_dl_q[i-1];
			for (int i = 1; i < U_DLY; i++)
				u_dl_q[i] <= u_dl_q[i-1];
			for (int i = 1; i < SM_DLY; i++) begin
				sm_dl_q[i] <= sm_dl_q[i-1];
				sr_dl_q[i] <= sr_dl_q[i-1];
			end
			for (int i = 1; i < BAD_DLY; i++)
				bad_dl_q[i] <= bad_dl_q[i-1];
			for (int i = 1; i < P_DLY; i++)
				p_dl_q[i] <= p_dl_q[i-1];
		end
	end

	// ------------------------------------------------------------------
	// Stage D: divisor d = (u * cos) >> 30 and dividend sin << 16. A
	// non-positive cosine or divisor gives the saturated ratio instead.
	// ------------------------------------------------------------------
	logic signed [U_W+C_W:0] dprod;
	logic signed [U_W+C_W:0] dsh;
	logic [SN_W-1:0]         sn;
	logic [D_W-1:0]          d_s52;
	logic [NQ_W-1:0]         nq_s52;

	always_comb begin
		dprod = $signed({1'b0, u_dl_q[U_DLY-1]}) * cx[CORDIC_N];
		dsh   = dprod >>> 30;
		sn    = cy[CORDIC_N][C_W-1] ? '0 : cy[CORDIC_N][SN_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s52   <= dsh[D_W-1:0];
			nq_s52  <= {sn, 16'h0000};
			bad_s52 <= (cx[CORDIC_N] <= 0) || (dsh <= 0);
		end
	end

	// ------------------------------------------------------------------
	// Divider chain: one quotient bit per cell.
	// ------------------------------------------------------------------
	logic [D_W-1:0]  dv_rem [DIV_N+1];
	logic [NQ_W-1:0] dv_nq  [DIV_N+1];
	logic [D_W-1:0]  dv_d   [DIV_N+1];

	assign dv_rem[0] = '0;
	assign dv_nq[0]  = nq_s52;
	assign dv_d[0]   = d_s52;

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		fovlda_div_cell u_cell (
			.clk     (clk),
			.en      (adv),
			.rem_in  (dv_rem[k]),
			.nq_in   (dv_nq[k]),
			.d_in    (dv_d[k]),
			.rem_out (dv_rem[k+1]),
			.nq_out  (dv_nq[k+1]),
			.d_out   (dv_d[k+1])
		);
	end

	// ------------------------------------------------------------------
	// Ratio and scale factor.
	// ------------------------------------------------------------------
	logic [NQ_W-1:0]       qc;
	logic signed [R_W-1:0] ratio_s101;
	logic signed [F_W-1:0] f_s102;

	assign qc = (dv_nq[DIV_N] > Q_LIM) ? Q_LIM : dv_nq[DIV_N];

	always_ff @(posedge clk) begin
		if (adv) begin
			if (sm_dl_q[SM_DLY-1])
				ratio_s101 <= $signed(R_W'(sr_dl_q[SM_DLY-1]));
			else if (bad_dl_q[BAD_DLY-1])
				ratio_s101 <= ACC_LIM;
			else
				ratio_s101 <= $signed(qc[R_W-1:0]);
			f_s102 <= F_W'(p_dl_q[P_DLY-1]) + F_W'(ratio_s101);
		end
	end

	// ------------------------------------------------------------------
	// Output stage: scale, round half up, saturate. An argument at or past
	// pi/2 replaces each coordinate by the rail of its sign.
	// ------------------------------------------------------------------
	logic signed [XW-1:0]   x_f;
	logic signed [XW-1:0]   y_f;
	logic                   ovf_f;
	logic signed [OP_W-1:0] px;
	logic signed [OP_W-1:0] py;
	logic signed [OP_W-17:0] ox;
	logic signed [OP_W-17:0] oy;
	logic signed [XW-1:0]   sx;
	logic signed [XW-1:0]   sy;
	logic                   sat_x;
	logic                   sat_y;
	logic signed [XW-1:0]   x_out_q;
	logic signed [XW-1:0]   y_out_q;
	logic                   flag_q;

	assign x_f   = x_dl_q[XY_DLY-1];
	assign y_f   = y_dl_q[XY_DLY-1];
	assign ovf_f = ovf_dl_q[OVF_DLY-1];

	always_comb begin
		px = x_f * f_s102 + OP_W'(32768);
		py = y_f * f_s102 + OP_W'(32768);
		ox = px[OP_W-1:16];
		oy = py[OP_W-1:16];
		sat_x = 1'b0;
		sat_y = 1'b0;
		if (ox > OUT_MAX) begin
			sx = OUT_MAX;
			sat_x = 1'b1;
		end else if (ox < OUT_MIN) begin
			sx = OUT_MIN;
			sat_x = 1'b1;
		end else begin
			sx = ox[XW-1:0];
		end
		if (oy > OUT_MAX) begin
			sy = OUT_MAX;
			sat_y = 1'b1;
		end else if (oy < OUT_MIN) begin
			sy = OUT_MIN;
			sat_y = 1'b1;
		end else begin
			sy = oy[XW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (ovf_f) begin
				x_out_q <= (x_f > 0) ? OUT_MAX : ((x_f < 0) ? OUT_MIN : '0);
				y_out_q <= (y_f > 0) ? OUT_MAX : ((y_f < 0) ? OUT_MIN : '0);
				flag_q  <= 1'b1;
			end else begin
				x_out_q <= sx;
				y_out_q <= sy;
				flag_q  <= sat_x | sat_y;
			end
		end
	end

	assign x_out      = x_out_q;
	assign y_out      = y_out_q;
	assign range_flag = flag_q;

`ifndef SYNTH
	// A held output freezes every stage valid bit.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> vld_q == $past(vld_q))
		else $error("pipeline valid bits moved during a stall");

	// An argument at or past pi/2 always raises the flag.
	a_ovf_flag: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[ST_F] && ovf_f |=> range_flag)
		else $error("range flag missing for an out-of-range argument");

	// The tangent ratio stays within zero and the accumulator limit.
	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[ST_Q] |=> (ratio_s101 >= 0) && (ratio_s101 <= ACC_LIM))
		else $error("tangent ratio out of range");
`endif

endmodule

// ===== rtl/fovlda_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// Square root cell
// Produces one root bit per enabled cycle from the next two radicand bits.
// ----------------------------------------------------------------------------
module fovlda_sqrt_cell import fovlda_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [RAD_W-1:0]    rad_in,
	input  logic [SQ_REM_W-1:0] rem_in,
	input  logic [ROOT_W-1:0]   root_in,
	output logic [RAD_W-1:0]    rad_out,
	output logic [SQ_REM_W-1:0] rem_out,
	output logic [ROOT_W-1:0]   root_out
);

	logic [SQ_REM_W+1:0] rem2;
	logic [SQ_REM_W+1:0] trial;
	logic [SQ_REM_W+1:0] diff;
	logic                ge;
	logic [RAD_W-1:0]    rad_s1;
	logic [SQ_REM_W-1:0] rem_s1;
	logic [ROOT_W-1:0]   root_s1;

	always_comb begin
		rem2  = {rem_in, rad_in[RAD_W-1 -: 2]};
		trial = {2'b00, root_in, 2'b01};
		diff  = rem2 - trial;
		ge    = (rem2 >= trial);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= {rad_in[RAD_W-3:0], 2'b00};
			rem_s1  <= ge ? diff[SQ_REM_W-1:0] : rem2[SQ_REM_W-1:0];
			root_s1 <= {root_in[ROOT_W-2:0], ge};
		end
	end

	assign rad_out  = rad_s1;
	assign rem_out  = rem_s1;
	assign root_out = root_s1;

endmodule

// ===== rtl/fovlda_horner_cell.sv =====
// ----------------------------------------------------------------------------
// Horner cell
// Horner step: p <- clamp(c + clamp((p * r) >> 16)), c = coef_en ? coef : 0.
// ----------------------------------------------------------------------------
module fovlda_horner_cell import fovlda_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [P_W-1:0]    p_in,
	input  logic [ROOT_W-1:0]        r_in,
	input  logic signed [COEF_W-1:0] coef,
	input  logic                     coef_en,
	output logic signed [P_W-1:0]    p_out,
	output logic [ROOT_W-1:0]        r_out
);

	localparam int PROD_W = P_W + ROOT_W + 1;

	logic signed [PROD_W-1:0] prod;
	logic signed [P_W-1:0]    mr;
	logic signed [P_W:0]      sum;
	logic signed [P_W-1:0]    p_s1;
	logic [ROOT_W-1:0]        r_s1;

	always_comb begin
		prod = p_in * $signed({1'b0, r_in});
		mr   = clamp_acc(CLAMP_W'($signed(prod[PROD_W-1:16])));
		sum  = (P_W+1)'(mr) + (coef_en ? (P_W+1)'(coef) : '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= clamp_acc(CLAMP_W'(sum));
			r_s1 <= r_in;
		end
	end

	assign p_out = p_s1;
	assign r_out = r_s1;

endmodule

// ===== rtl/fovlda_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// Rotation cell
// One CORDIC rotation step in Q.30, the step index fixing shift and angle.
// ----------------------------------------------------------------------------
module fovlda_cordic_cell import fovlda_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [C_W-1:0] cx_in,
	input  logic signed [C_W-1:0] cy_in,
	input  logic signed [C_W-1:0] z_in,
	output logic signed [C_W-1:0] cx_out,
	output logic signed [C_W-1:0] cy_out,
	output logic signed [C_W-1:0] z_out
);

	logic signed [C_W-1:0] sx;
	logic signed [C_W-1:0] sy;
	logic signed [C_W-1:0] ang;
	logic signed [C_W-1:0] cx_s1;
	logic signed [C_W-1:0] cy_s1;
	logic signed [C_W-1:0] z_s1;

	always_comb begin
		sx  = cx_in >>> IDX;
		sy  = cy_in >>> IDX;
		ang = $signed({2'b00, ATAN_Q30[IDX]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[C_W-1]) begin
				cx_s1 <= cx_in - sy;
				cy_s1 <= cy_in + sx;
				z_s1  <= z_in - ang;
			end else begin
				cx_s1 <= cx_in + sy;
				cy_s1 <= cy_in - sx;
				z_s1  <= z_in + ang;
			end
		end
	end

	assign cx_out = cx_s1;
	assign cy_out = cy_s1;
	assign z_out  = z_s1;

endmodule

// ===== rtl/fovlda_div_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step; dividend bits leave the top of nq as
// quotient bits enter at the bottom.
// ----------------------------------------------------------------------------
module fovlda_div_cell import fovlda_pkg::*; (
	input  logic            clk,
	input  logic            en,
	input  logic [D_W-1:0]  rem_in,
	input  logic [NQ_W-1:0] nq_in,
	input  logic [D_W-1:0]  d_in,
	output logic [D_W-1:0]  rem_out,
	output logic [NQ_W-1:0] nq_out,
	output logic [D_W-1:0]  d_out
);

	logic [D_W:0]    rem_sh;
	logic [D_W:0]    diff;
	logic            ge;
	logic [D_W-1:0]  rem_s1;
	logic [NQ_W-1:0] nq_s1;
	logic [D_W-1:0]  d_s1;

	always_comb begin
		rem_sh = {rem_in, nq_in[NQ_W-1]};
		diff   = rem_sh - {1'b0, d_in};
		ge     = (rem_sh >= {1'b0, d_in});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= ge ? diff[D_W-1:0] : rem_sh[D_W-1:0];
			nq_s1  <= {nq_in[NQ_W-2:0], ge};
			d_s1   <= d_in;
		end
	end

	assign rem_out = rem_s1;
	assign nq_out  = nq_s1;
	assign d_out   = d_s1;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FOV lens distortion apply unit: self-checking testbench
// Points go in through a queue-fed driver and results come back through a
// monitor. Each result is compared, field by field, with an in-bench
// fixed-point prediction. Both sides idle at random, and the register
// settings change between phases, including the extreme settings.
// ----------------------------------------------------------------------------
module tb_top;
	import fovlda_pkg::*;

	localparam int  PIPE_DEPTH  = 103;
	localparam int  CYCLE_LIMIT = 600000;
	localparam longint ACC_MAX  = 64'sd1 << 40;
	localparam longint OUT_HI   = 131071;
	localparam longint OUT_LO   = -131072;

	typedef struct {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
	} point_t;

	typedef struct {
		logic signed [XW-1:0] x;
		logic signed [XW-1:0] y;
		logic                 flag;
	} warped_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic signed [XW-1:0]  x_in = '0;
	logic signed [XW-1:0]  y_in = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [XW-1:0]  x_out;
	logic signed [XW-1:0]  y_out;
	logic                  range_flag;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_W-1:0]      cfg_wdata = '0;

	// Shadow copy of the register file, used by the prediction.
	logic [T_W-1:0]        lens_tan = TAN_RESET;
	logic [TERMS_W-1:0]    lens_terms = TERMS_RESET;
	longint                lens_coef [NCOEF];

	point_t                pending_points [$];
	warped_t               expected_points [$];
	bit                    idle_on = 1'b1;
	bit                    in_taken = 1'b0;
	int                    in_gap = 0;
	int                    out_gap = 0;
	int                    errors = 0;
	int                    cycles = 0;

	fov_lens_distortion_apply_unit uut (.*);

	always #5 clk = ~clk;

	// Integer square root, one result bit per pass.
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint acc_clamp(input longint v);
		return v > ACC_MAX ? ACC_MAX : (v < -ACC_MAX ? -ACC_MAX : v);
	endfunction

	// tan(u)/u in Q.16, with u in Q.30.
	function automatic longint tan_over_arg(input longint u);
		longint cx, cy, z, nx, ny, d, sn, q;
		cx = longint'(CORDIC_K_Q30);
		cy = 0;
		z = u;
		if (u < (64'sd1 << 24))
			return 65536 + ((u * u) >>> 44) / 3;
		for (int i = 0; i < CORDIC_N; i++) begin
			if (z >= 0) begin
				nx = cx - (cy >>> i);
				ny = cy + (cx >>> i);
				z = z - longint'(ATAN_Q30[i]);
			end else begin
				nx = cx + (cy >>> i);
				ny = cy - (cx >>> i);
				z = z + longint'(ATAN_Q30[i]);
			end
			cx = nx;
			cy = ny;
		end
		if (cx <= 0)
			return ACC_MAX;
		d = (u * cx) >>> 30;
		if (d <= 0)
			return ACC_MAX;
		sn = cy < 0 ? 0 : cy;
		q = (sn <<< 16) / d;
		return q > ACC_MAX ? ACC_MAX : q;
	endfunction

	function automatic longint scale_coord(input longint v, input longint f, inout bit sat);
		longint o;
		o = (v * f + 32768) >>> 16;
		if (o > OUT_HI) begin
			sat = 1'b1;
			return OUT_HI;
		end
		if (o < OUT_LO) begin
			sat = 1'b1;
			return OUT_LO;
		end
		return o;
	endfunction

	// Distorted point for the current register settings.
	function automatic warped_t warp_point(input point_t pt);
		warped_t w;
		longint x, y, r, u, p, f, xo, yo;
		longint unsigned ss;
		int n;
		bit sat;
		x = pt.x;
		y = pt.y;
		ss = longint'(x * x + y * y);
		r = longint'(int_sqrt(ss << 2));
		u = (r * longint'(lens_tan)) >>> 1;
		n = lens_terms > NCOEF ? NCOEF : int'(lens_terms);
		p = 0;
		sat = 1'b0;
		if (u >= longint'(HALF_PI_Q30)) begin
			sat = 1'b1;
			xo = x > 0 ? OUT_HI : (x < 0 ? OUT_LO : 0);
			yo = y > 0 ? OUT_HI : (y < 0 ? OUT_LO : 0);
		end else begin
			// Horner with the r^2 term missing: an extra multiply before c1.
			for (int i = n - 1; i >= 0; i--) begin
				if (i == 1)
					p = acc_clamp((p * r) >>> 16);
				p = acc_clamp(lens_coef[i] + acc_clamp((p * r) >>> 16));
			end
			f = p + tan_over_arg(u);
			xo = scale_coord(x, f, sat);
			yo = scale_coord(y, f, sat);
		end
		w.x = xo[XW-1:0];
		w.y = yo[XW-1:0];
		w.flag = sat;
		return w;
	endfunction

	// Sender: a new transaction is offered at the falling edge once the last
	// one has been taken, unless an idle burst is running.
	always @(negedge clk) begin
		point_t pt;
		bit nv;
		if (arst_n && (!in_valid || in_taken)) begin
			nv = 1'b0;
			if (in_gap > 0) begin
				in_gap--;
			end else if (pending_points.size() > 0) begin
				pt = pending_points.pop_front();
				nv = 1'b1;
				x_in <= pt.x;
				y_in <= pt.y;
				if (idle_on && $urandom_range(0, 7) == 0)
					in_gap = $urandom_range(1, 19);
			end
			in_valid <= nv;
		end
	end

	// Receiver: stalls in random bursts while idling is enabled.
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					out_gap = $urandom_range(1, 19);
			end
		end
	end

	// Monitor: predicts on every accepted input and checks every result.
	always @(posedge clk) begin
		warped_t w;
		point_t pt;
		cycles <= cycles + 1;
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			pt.x = x_in;
			pt.y = y_in;
			expected_points.push_back(warp_point(pt));
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_points.size() == 0) begin
				errors++;
				$display("%0t: unexpected result x=%0d y=%0d flag=%0b",
					$time, x_out, y_out, range_flag);
			end else begin
				w = expected_points.pop_front();
				if (x_out !== w.x) begin
					errors++;
					$display("%0t: x_out expected %0d actual %0d", $time, w.x, x_out);
				end
				if (y_out !== w.y) begin
					errors++;
					$display("%0t: y_out expected %0d actual %0d", $time, w.y, y_out);
				end
				if (range_flag !== w.flag) begin
					errors++;
					$display("%0t: range_flag expected %0b actual %0b",
						$time, w.flag, range_flag);
				end
			end
		end
	end

	// Guard against a hung pipeline.
	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_TAN_HALF_FOV: lens_tan = val[T_W-1:0];
			REG_TERMS_IN_USE: lens_terms = val[TERMS_W-1:0];
			default:          lens_coef[int'(idx) - int'(REG_COEF_C0)] = longint'($signed(val));
		endcase
	endtask

	// Waits until the sender has drained and every result is back, then lets
	// the pipeline run empty before anything else happens.
	task automatic wait_drained();
		while (pending_points.size() > 0 || in_valid || expected_points.size() > 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	function automatic logic signed [XW-1:0] rand_coord();
		logic signed [XW-1:0] v;
		case ($urandom_range(0, 5))
			0, 1: v = XW'($urandom);
			2:    v = XW'($signed(XW'($urandom_range(0, 2047))) - 1024);
			3:    v = XW'($signed(XW'($urandom_range(0, 32767))) - 16384);
			4:    v = $urandom_range(0, 1) ? OUT_MAX : OUT_MIN;
			default: v = '0;
		endcase
		return v;
	endfunction

	task automatic queue_point(input logic signed [XW-1:0] x, input logic signed [XW-1:0] y);
		point_t pt;
		pt.x = x;
		pt.y = y;
		pending_points.push_back(pt);
	endtask

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++)
			queue_point(rand_coord(), rand_coord());
	endtask

	task automatic random_coefs();
		for (int i = 0; i < NCOEF; i++)
			write_reg(reg_idx_t'(int'(REG_COEF_C0) + i),
				$urandom_range(0, 3) == 0 ? CFG_W'($urandom)
					: CFG_W'($signed(CFG_W'($urandom_range(0, 131071))) - 65536));
	endtask

	initial begin
		for (int i = 0; i < NCOEF; i++)
			lens_coef[i] = 0;
		lens_coef[0] = longint'(COEF0_RESET);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: the corners, the axes, zero radius and the small
		// argument range where the ratio comes from the series.
		queue_point(18'sd0, 18'sd0);
		queue_point(OUT_MAX, OUT_MAX);
		queue_point(OUT_MIN, OUT_MIN);
		queue_point(OUT_MAX, OUT_MIN);
		queue_point(OUT_MAX, 18'sd0);
		queue_point(18'sd0, OUT_MIN);
		queue_point(18'sd1, 18'sd0);
		queue_point(-18'sd1, -18'sd1);
		queue_point(18'sd500, -18'sd300);
		queue_point(-18'sd886, 18'sd0);
		queue_point(18'sd20000, 18'sd30000);
		queue_point(-18'sd60000, 18'sd45000);
		queue_point(-18'sd1, 18'sd2);
		queue_random(110);
		wait_drained();

		// Zero tangent, no polynomial terms.
		write_reg(REG_TAN_HALF_FOV, '0);
		write_reg(REG_TERMS_IN_USE, '0);
		queue_point(OUT_MAX, OUT_MIN);
		queue_random(110);
		wait_drained();

		// Widest tangent, count above the coefficient range, random terms.
		write_reg(REG_TAN_HALF_FOV, 24'hFFFF);
		write_reg(REG_TERMS_IN_USE, 24'd7);
		random_coefs();
		queue_point(18'sd1, 18'sd1);
		queue_random(110);
		wait_drained();

		// Extreme coefficients, all six terms, moderate tangent.
		write_reg(REG_TAN_HALF_FOV, 24'd8000);
		write_reg(REG_TERMS_IN_USE, 24'd6);
		for (int i = 0; i < NCOEF; i++)
			write_reg(reg_idx_t'(int'(REG_COEF_C0) + i), i[0] ? 24'h800000 : 24'h7FFFFF);
		queue_random(110);
		wait_drained();

		// Three terms, with a pause until everything is back mid-phase.
		write_reg(REG_TAN_HALF_FOV, 24'd18919);
		write_reg(REG_TERMS_IN_USE, 24'd3);
		random_coefs();
		queue_random(60);
		wait_drained();
		queue_random(60);
		wait_drained();

		// A sequence of random settings.
		for (int ph = 0; ph < 2; ph++) begin
			write_reg(REG_TAN_HALF_FOV, CFG_W'($urandom_range(0, 65535)));
			write_reg(REG_TERMS_IN_USE, CFG_W'($urandom_range(0, 7)));
			random_coefs();
			queue_random(100);
			wait_drained();
		end

		// Final stretch at full rate on both sides.
		idle_on = 1'b0;
		write_reg(REG_TAN_HALF_FOV, 24'd4000);
		write_reg(REG_TERMS_IN_USE, 24'd2);
		random_coefs();
		queue_random(80);
		wait_drained();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
